/* rtl/bko_pkg.sv */
package bko_pkg;

    localparam int MAX_BOXES_DEF  = 8;
    localparam int COORD_BITS_DEF = 13;
    localparam int KP_PER_BOX     = 5;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_COLOR    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THICKNESS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOT_SIZE     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_EYE_COLOR    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_NOSE_COLOR   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_MOUTH_COLOR  = 3'd7;

    // Action codes.
    localparam logic [1:0] ACT_LOAD_RECT  = 2'd0;
    localparam logic [1:0] ACT_LOAD_POINT = 2'd1;
    localparam logic [1:0] ACT_SET_COUNT  = 2'd2;
    localparam logic [1:0] ACT_PIXEL      = 2'd3;

    // Settings that the hit units share.
    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [3:0]  thickness;
        logic [3:0]  dot_size;
    } t_geom_cfg;

endpackage

/* rtl/bko_rect_hit.sv */
// Outline test of one box, split over three register stages.
// Stage 1 clips the box to the frame, stage 2 forms the ring distances,
// stage 3 decides whether the pixel lies on one of the rings.
module bko_rect_hit #(
    parameter int COORD_BITS = bko_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  bko_pkg::t_geom_cfg           i_cfg,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic [11:0]                  i_bw,
    input  logic [11:0]                  i_bh,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output logic                         o_hit
);
    import bko_pkg::*;

    localparam int W = COORD_BITS + 3;

    logic signed [W-1:0] n_rx, n_ry, n_rw, n_rh, n_r, n_b;
    logic signed [W-1:0] r_rx, r_ry, r_rw, r_rh, r_px1, r_py1;
    logic                n_ok, r_ok;
    logic signed [W-1:0] r_dl, r_dr, r_dt, r_db, n_dl, n_dr, n_dt, n_db;
    logic                r_ok2;
    logic [3:0]          r_th2;
    logic                n_hit, r_hit;
    logic signed [W-1:0] fw, fh, px, py;
    logic signed [W-1:0] t_top, t_bot, t_lft, t_rgt, lo_c, lo_r;

    assign fw = W'(i_cfg.frame_width);
    assign fh = W'(i_cfg.frame_height);
    assign px = W'(i_px);
    assign py = W'(i_py);

    // Clip the rectangle to the frame.
    always_comb begin
        n_rx = W'(i_bx);
        n_ry = W'(i_by);
        n_rw = W'(i_bw);
        n_rh = W'(i_bh);
        if (n_rx < 0) begin
            n_rw = n_rw + n_rx;
            n_rx = '0;
        end
        if (n_ry < 0) begin
            n_rh = n_rh + n_ry;
            n_ry = '0;
        end
        n_r = n_rx + n_rw;
        n_b = n_ry + n_rh;
        if (n_r > fw) n_rw = fw - n_rx;
        if (n_b > fh) n_rh = fh - n_ry;
        n_ok = (n_rw > 0) && (n_rh > 0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_rw  <= n_rw;
            r_rh  <= n_rh;
            r_ok  <= n_ok;
            r_px1 <= px;
            r_py1 <= py;
        end
    end

    // Distances of the pixel from each clipped edge, inward positive.
    always_comb begin
        n_dl = r_px1 - r_rx;
        n_dr = r_rx + r_rw - 1 - r_px1;
        n_dt = r_py1 - r_ry;
        n_db = r_ry + r_rh - 1 - r_py1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl  <= n_dl;
            r_dr  <= n_dr;
            r_dt  <= n_dt;
            r_db  <= n_db;
            r_ok2 <= r_ok;
            r_th2 <= i_cfg.thickness;
        end
    end

    // Ring t: the row at distance t from the top or bottom covers the
    // columns with both column distances at least t; a column at distance
    // t covers rows strictly inside the pair of rows of ring t.
    // Top row hit on ring t=dt needs dl>=t and dr>=t.
    // Bottom row (row = ry+rh-1-t) with t=db, needs dl,dr>=t and bot!=top,
    // i.e. dt != db.  Column hits need dt>t and db>t with t=dl or t=dr.
    always_comb begin
        t_top = r_dt;
        t_bot = r_db;
        t_lft = r_dl;
        t_rgt = r_dr;
        lo_c  = (r_dl < r_dr) ? r_dl : r_dr;
        lo_r  = (r_dt < r_db) ? r_dt : r_db;
        n_hit = 1'b0;
        if (r_ok2) begin
            if (t_top >= 0 && t_top < W'(r_th2) && lo_c >= t_top) n_hit = 1'b1;
            if (t_bot >= 0 && t_bot < W'(r_th2) && lo_c >= t_bot && t_bot != t_top)
                n_hit = 1'b1;
            if (t_lft >= 0 && t_lft < W'(r_th2) && lo_r > t_lft) n_hit = 1'b1;
            if (t_rgt >= 0 && t_rgt < W'(r_th2) && lo_r > t_rgt) n_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

/* rtl/bko_dot_hit.sv */
// Disc test of one keypoint over three register stages: offsets, then
// magnitudes and the bounding square, then the compare against the squared
// radius.
module bko_dot_hit #(
    parameter int COORD_BITS = bko_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [3:0]                   i_dot_size,
    input  logic signed [COORD_BITS-1:0] i_kx,
    input  logic signed [COORD_BITS-1:0] i_ky,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output logic                         o_hit
);
    import bko_pkg::*;

    localparam int W = COORD_BITS + 1;

    logic signed [W-1:0] n_dx, n_dy, r_dx, r_dy;
    logic                r_on;
    logic [2:0]          r_r1, r_r2;
    logic signed [W-1:0] rr;
    logic                n_box, r_box;
    logic [2:0]          n_ax, n_ay, r_ax, r_ay;
    logic [6:0]          n_sum, n_rr;
    logic                r_hit;

    assign n_dx = W'(i_px) - W'(i_kx);
    assign n_dy = W'(i_py) - W'(i_ky);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_on <= (i_kx > 0);
            r_r1 <= i_dot_size[3:1];
        end
    end

    // Inside the bounding square the offsets fit in three bits.
    assign rr    = W'(r_r1);
    assign n_box = r_on && r_dx >= -rr && r_dx <= rr && r_dy >= -rr && r_dy <= rr;
    assign n_ax  = r_dx[W-1] ? 3'(-r_dx) : 3'(r_dx);
    assign n_ay  = r_dy[W-1] ? 3'(-r_dy) : 3'(r_dy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_box <= n_box;
            r_r2  <= r_r1;
        end
    end

    // Squared distance against the squared radius.
    assign n_sum = {4'd0, r_ax} * {4'd0, r_ax} + {4'd0, r_ay} * {4'd0, r_ay};
    assign n_rr  = {4'd0, r_r2} * {4'd0, r_r2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= r_box && (n_sum <= n_rr);
        end
    end

    assign o_hit = r_hit;

endmodule

/* rtl/box_and_keypoint_overlay.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | i_valid / o_stall    | action, slot, point, pos, size, pixel, count
// out     | output    | o_valid / i_stall    | pixel_out, overlaid
// cfg     | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
// One item per clock unless a held result stalls the pipeline. The depth of a pixel
// result is set by the hit unit stages, the hit registers and the colour register.
// Loads take effect for pixels accepted in later cycles; they give no result.
// Reset clears the valid bits of the pipeline and the box count and loads the default configuration.
// A stall while a result is held at the output freezes the whole pipeline; no item is lost.
module box_and_keypoint_overlay #(
    parameter int MAX_BOXES  = bko_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bko_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic [2:0]                           i_slot,
    input  logic [2:0]                           i_point,
    input  logic signed [COORD_BITS-1:0]         i_pos_x,
    input  logic signed [COORD_BITS-1:0]         i_pos_y,
    input  logic [11:0]                          i_size_w,
    input  logic [11:0]                          i_size_h,
    input  logic [15:0]                          i_pixel_value,
    input  logic [3:0]                           i_box_count,
    input  logic                                 i_cfg_we,
    input  logic [bko_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [bko_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [15:0]                          o_pixel_out,
    output logic                                 o_overlaid
);
    import bko_pkg::*;

    localparam int NK    = MAX_BOXES * KP_PER_BOX;
    localparam int NBITS = $clog2(MAX_BOXES + 1);
    localparam int DEPTH = 5;

    // Configuration registers.
    t_geom_cfg   r_geom;
    logic [15:0] r_box_color, r_eye_color, r_nose_color, r_mouth_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.frame_width  <= 12'd640;
            r_geom.frame_height <= 12'd480;
            r_geom.thickness    <= 4'd3;
            r_geom.dot_size     <= 4'd4;
            r_box_color         <= 16'hF800;
            r_eye_color         <= 16'h07FF;
            r_nose_color        <= 16'hFFE0;
            r_mouth_color       <= 16'hF81F;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_geom.frame_width  <= i_cfg_data[11:0];
                REG_FRAME_HEIGHT: r_geom.frame_height <= i_cfg_data[11:0];
                REG_BOX_COLOR:    r_box_color         <= i_cfg_data;
                REG_THICKNESS:    r_geom.thickness    <= i_cfg_data[3:0];
                REG_DOT_SIZE:     r_geom.dot_size     <= i_cfg_data[3:0];
                REG_EYE_COLOR:    r_eye_color         <= i_cfg_data;
                REG_NOSE_COLOR:   r_nose_color        <= i_cfg_data;
                REG_MOUTH_COLOR:  r_mouth_color       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a finished result is held by the consumer.
    logic r_vld [DEPTH];
    logic en;
    assign en      = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !en;

    logic acc;
    assign acc = i_valid && en;

    // Box and keypoint tables, one register set per entry.
    logic signed [COORD_BITS-1:0] r_bx [MAX_BOXES];
    logic signed [COORD_BITS-1:0] r_by [MAX_BOXES];
    logic [11:0]                  r_bw [MAX_BOXES];
    logic [11:0]                  r_bh [MAX_BOXES];
    logic signed [COORD_BITS-1:0] r_kx [NK];
    logic signed [COORD_BITS-1:0] r_ky [NK];
    logic [NBITS-1:0]             r_count;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_BOXES; i++) begin
            if (acc && i_action == ACT_LOAD_RECT && 32'(i_slot) == i) begin
                r_bx[i] <= i_pos_x;
                r_by[i] <= i_pos_y;
                r_bw[i] <= i_size_w;
                r_bh[i] <= i_size_h;
            end
        end
        for (int k = 0; k < NK; k++) begin
            if (acc && i_action == ACT_LOAD_POINT && i_point < 3'(KP_PER_BOX)
                && 32'(i_slot) * KP_PER_BOX + 32'(i_point) == k) begin
                r_kx[k] <= i_pos_x;
                r_ky[k] <= i_pos_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (acc && i_action == ACT_SET_COUNT) begin
            r_count <= (32'(i_box_count) > MAX_BOXES) ? NBITS'(MAX_BOXES)
                                                       : NBITS'(i_box_count);
        end
    end

    // Valid bits and pass-through data travel alongside the hit units.
    logic [15:0]      r_pix [DEPTH-1];
    logic             r_inf [DEPTH-1];
    logic [NBITS-1:0] r_cnt [DEPTH-1];
    logic             n_inf;

    assign n_inf = !i_pos_x[COORD_BITS-1] && !i_pos_y[COORD_BITS-1]
                   && 32'(i_pos_x) < 32'(r_geom.frame_width)
                   && 32'(i_pos_y) < 32'(r_geom.frame_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) r_vld[s] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid && i_action == ACT_PIXEL;
            for (int s = 1; s < DEPTH; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix[0] <= i_pixel_value;
            r_inf[0] <= n_inf;
            r_cnt[0] <= r_count;
            for (int s = 1; s < DEPTH-1; s++) begin
                r_pix[s] <= r_pix[s-1];
                r_inf[s] <= r_inf[s-1];
                r_cnt[s] <= r_cnt[s-1];
            end
        end
    end

    // One hit unit per box outline and per keypoint.
    logic rect_hit [MAX_BOXES];
    logic dot_hit  [NK];

    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_box
        bko_rect_hit #(.COORD_BITS(COORD_BITS)) u_rect (
            .i_clk (i_clk), .i_en (en), .i_cfg (r_geom),
            .i_bx (r_bx[g]), .i_by (r_by[g]), .i_bw (r_bw[g]), .i_bh (r_bh[g]),
            .i_px (i_pos_x), .i_py (i_pos_y), .o_hit (rect_hit[g])
        );
    end

    for (genvar g = 0; g < NK; g++) begin : g_dot
        bko_dot_hit #(.COORD_BITS(COORD_BITS)) u_dot (
            .i_clk (i_clk), .i_en (en), .i_dot_size (r_geom.dot_size),
            .i_kx (r_kx[g]), .i_ky (r_ky[g]), .i_px (i_pos_x), .i_py (i_pos_y),
            .o_hit (dot_hit[g])
        );
    end

    // Hits line up with stage three; register them, then pick the last draw.
    logic [MAX_BOXES-1:0] r_rh;
    logic [NK-1:0]        r_dh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < MAX_BOXES; i++) r_rh[i] <= rect_hit[i];
            for (int k = 0; k < NK; k++) r_dh[k] <= dot_hit[k];
        end
    end

    logic [15:0] n_col, r_col;
    logic        n_hit, r_hit;

    always_comb begin
        n_col = r_pix[3];
        n_hit = 1'b0;
        for (int i = 0; i < MAX_BOXES; i++) begin
            if (r_inf[3] && i < 32'(r_cnt[3])) begin
                if (r_rh[i]) begin
                    n_col = r_box_color;
                    n_hit = 1'b1;
                end
                for (int k = 0; k < KP_PER_BOX; k++) begin
                    if (r_dh[i*KP_PER_BOX+k]) begin
                        n_col = (k < 2) ? r_eye_color
                              : ((k == 2) ? r_nose_color : r_mouth_color);
                        n_hit = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col <= n_col;
            r_hit <= n_hit;
        end
    end

    assign o_valid     = r_vld[DEPTH-1];
    assign o_pixel_out = r_col;
    assign o_overlaid  = r_hit;

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without a held result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_out)))
        else $error("held result changed");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_BOXES) else $error("box count out of range");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overlaid) |-> o_pixel_out == $past(r_pix[DEPTH-2], 1)
        || $past(!en)) else $error("uncovered pixel altered");
`endif

endmodule
